// ----- hdl/tss_pkg.sv -----
// Shared types and constants of the triangle sphere subdivider.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tss_pkg;

  localparam int unsigned COORD_W     = 24;               // Q8.16 coordinates
  localparam int unsigned IDX_W       = 16;               // running vertex index
  localparam int unsigned NRM_W       = 16;               // Q2.14 normals
  localparam int unsigned RAD_W       = 23;               // radius register
  localparam int unsigned NORM_IN_W   = 2 * (COORD_W + 1) + 1;  // cross product range
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_MODE = 1'b1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd65536;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_pos_x;
    logic signed [COORD_W-1:0] in_pos_y;
    logic signed [COORD_W-1:0] in_pos_z;
    logic signed [COORD_W-1:0] in_tex_u;
    logic signed [COORD_W-1:0] in_tex_v;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_pos_x;
    logic signed [COORD_W-1:0] out_pos_y;
    logic signed [COORD_W-1:0] out_pos_z;
    logic signed [NRM_W-1:0]   out_norm_x;
    logic signed [NRM_W-1:0]   out_norm_y;
    logic signed [NRM_W-1:0]   out_norm_z;
    logic signed [COORD_W-1:0] out_tex_u;
    logic signed [COORD_W-1:0] out_tex_v;
    logic [IDX_W-1:0]          out_vertex_index;
    logic                      out_last;
  } out_word_t;

  // one triangle: corner 0 first
  typedef struct packed {
    in_word_t [2:0] corner;
  } job_t;

  typedef struct packed {
    logic                        start;
    logic signed [NORM_IN_W-1:0] x;
    logic signed [NORM_IN_W-1:0] y;
    logic signed [NORM_IN_W-1:0] z;
  } norm_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } norm_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/triangle_sphere_subdivider_core.sv -----
// Vertices of a triangle follow its third corner once the back end has run the
// shared normalizer on all six vertices (and on four faces in face-normal mode);
// then one vertex per cycle while the output is not stalled.
// The back end works on one triangle at a time, its pace set by the shared
// normalizer (32-step square root, 15-step divide) run 6 or 10 times.
// Corners are taken every cycle while the job queue has room.
// Reset: asynchronous, clears counters and queue, radius 1.0, radial normals.
`default_nettype none

module triangle_sphere_subdivider_core
  import tss_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RAD_W-1:0]     cfg_data_i
);

  logic [RAD_W-1:0] radius_q;
  logic             face_mode_q;

  logic      push, full, job_valid, job_pop, busy;
  job_t      job_in, job_out;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RADIUS_RESET;
      face_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RADIUS:    radius_q    <= cfg_data_i;
        REG_FACE_MODE: face_mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  tss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  tss_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .data_o  (job_out)
  );

  tss_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .rsp_o  (norm_rsp)
  );

  tss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .radius_i    (radius_q),
    .face_mode_i (face_mode_q),
    .norm_req_o  (norm_req),
    .norm_rsp_i  (norm_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .busy_o      (busy)
  );

`ifndef SYNTH
  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> job_valid)
    else $error("back end busy without a queued triangle");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("triangle pushed into a full queue");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");
`endif

endmodule

`default_nettype wire

// ----- hdl/tss_front.sv -----
// Front end: collects corners and hands a full triangle to the job queue.
// Depends on tss_pkg.
`default_nettype none

module tss_front
  import tss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_data_i,
  output logic     push_o,
  output job_t     job_o,
  input  logic     full_i
);

  logic [1:0] corner_q, corner_d;
  in_word_t   held_q [2];
  logic       accept;

  assign in_stall_o = (corner_q == 2'd2) && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && (corner_q == 2'd2);

  assign job_o.corner[0] = held_q[0];
  assign job_o.corner[1] = held_q[1];
  assign job_o.corner[2] = in_data_i;

  always_comb begin
    corner_d = corner_q;
    if (accept) begin
      corner_d = (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 2'd0;
    end else begin
      corner_q <= corner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && corner_q != 2'd2) begin
      held_q[corner_q[0]] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tss_fifo.sv -----
// Short queue of triangle jobs between the front end and the back end.
// Depends on tss_pkg.
`default_nettype none

module tss_fifo
  import tss_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tss_norm.sv -----
// Shared vector normalizer: range reduction, sum of squares, bit-serial
// square root and three-lane restoring divide. Depends on tss_pkg.
`default_nettype none

module tss_norm
  import tss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  localparam int unsigned NW = NORM_IN_W;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_DSET  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]  st_q, st_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;

  logic [NW-1:0]           mag_q [3];
  logic                    neg_q [3];
  logic [47:0]             acc_q;
  logic [63:0]             rv_q, res_q, bit_q;
  logic [46:0]             rem_q [3];
  logic [46:0]             dsh_q;
  logic [14:0]             quo_q [3];
  logic signed [NRM_W-1:0] nrm_q [3];

  logic signed [NW-1:0] vin [3];
  logic                 big_hi, big_lo;
  logic [22:0]          sq_op;
  logic [47:0]          acc_sum;
  logic [63:0]          trial;
  logic [14:0]          quo_d [3];
  logic                 ge [3];

  assign vin[0] = req_i.x;
  assign vin[1] = req_i.y;
  assign vin[2] = req_i.z;

  always_comb begin
    big_hi = 1'b0;
    big_lo = 1'b0;
    for (int i = 0; i < 3; i++) begin
      big_hi = big_hi | (|mag_q[i][NW-1:31]);
      big_lo = big_lo | (|mag_q[i][NW-1:23]);
    end
  end

  assign sq_op   = mag_q[cnt_q[1:0]][22:0];
  assign acc_sum = acc_q + 48'(46'(sq_op) * 46'(sq_op));
  assign trial   = res_q + bit_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ge[i]    = (rem_q[i] >= dsh_q);
      quo_d[i] = {quo_q[i][13:0], ge[i]};
    end
  end

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (st_q)
      N_IDLE: begin
        if (req_i.start) begin
          st_d = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (!big_hi && !big_lo) begin
          st_d  = N_SQ;
          cnt_d = '0;
        end
      end
      N_SQ: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          cnt_d = '0;
          if (acc_sum == '0) begin
            st_d   = N_IDLE;
            done_d = 1'b1;
          end else begin
            st_d = N_ROOT;
          end
        end
      end
      N_ROOT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          st_d = N_DSET;
        end
      end
      N_DSET: begin
        st_d  = N_DIV;
        cnt_d = '0;
      end
      N_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd14) begin
          st_d   = N_IDLE;
          done_d = 1'b1;
        end
      end
      default: begin
        st_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= vin[i][NW-1];
          mag_q[i] <= vin[i][NW-1] ? NW'(-vin[i]) : NW'(vin[i]);
        end
        acc_q <= '0;
      end
      N_SHIFT: begin
        // truncating shifts compose, so reduce in coarse then fine steps
        for (int i = 0; i < 3; i++) begin
          if (big_hi) begin
            mag_q[i] <= mag_q[i] >> 8;
          end else if (big_lo) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end
      end
      N_SQ: begin
        acc_q <= acc_sum;
        if (cnt_q == 5'd2) begin
          rv_q  <= {acc_sum, 16'h0000};
          res_q <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
          if (acc_sum == '0) begin
            for (int i = 0; i < 3; i++) begin
              nrm_q[i] <= '0;
            end
          end
        end
      end
      N_ROOT: begin
        if (rv_q >= trial) begin
          rv_q  <= rv_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_DSET: begin
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= {1'b0, mag_q[i][22:0], 23'd0} + 47'(res_q[31:0]);
          quo_q[i] <= '0;
        end
        dsh_q <= {res_q[31:0], 1'b0, 14'd0};
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (ge[i]) begin
            rem_q[i] <= rem_q[i] - dsh_q;
          end
          quo_q[i] <= quo_d[i];
          if (cnt_q == 5'd14) begin
            nrm_q[i] <= neg_q[i] ? -$signed({1'b0, quo_d[i]}) : $signed({1'b0, quo_d[i]});
          end
        end
        dsh_q <= dsh_q >> 1;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = nrm_q[0];
  assign rsp_o.y    = nrm_q[1];
  assign rsp_o.z    = nrm_q[2];

endmodule

`default_nettype wire

// ----- hdl/tss_back.sv -----
// Back end: projects corners and midpoints onto the sphere, builds face
// normals in face-normal mode and streams twelve vertices. Depends on tss_pkg.
`default_nettype none

module tss_back
  import tss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  input  logic [RAD_W-1:0] radius_i,
  input  logic             face_mode_i,
  output norm_req_t        norm_req_o,
  input  norm_rsp_t        norm_rsp_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_data_o,
  output logic             busy_o
);

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_LOAD   = 4'd1;
  localparam logic [3:0] B_NWAIT  = 4'd2;
  localparam logic [3:0] B_PROJ   = 4'd3;
  localparam logic [3:0] B_FDIFF  = 4'd4;
  localparam logic [3:0] B_FMUL   = 4'd5;
  localparam logic [3:0] B_FSTART = 4'd6;
  localparam logic [3:0] B_FWAIT  = 4'd7;
  localparam logic [3:0] B_EMIT   = 4'd8;

  localparam int unsigned CW   = COORD_W;
  localparam int unsigned PW   = 15 + RAD_W;   // |n| times radius
  localparam int unsigned QW   = PW + 1 - 14;
  localparam int unsigned CMAX = (1 << (CW - 1)) - 1;
  localparam int unsigned MW   = 2 * (CW + 1);
  localparam logic [3:0]  LAST_VTX = 4'd11;
  localparam logic [IDX_W-1:0] VTX_PER_TRI = IDX_W'(12);

  // vertex slot per emitted vertex: (m01,c1,m12) (c0,m01,m02) (m01,m12,m02) (m02,m12,c2)
  function automatic logic [2:0] tri_vtx(input logic [3:0] k);
    logic [2:0] r;
    case (k)
      4'd0:    r = 3'd3;
      4'd1:    r = 3'd1;
      4'd2:    r = 3'd4;
      4'd3:    r = 3'd0;
      4'd4:    r = 3'd3;
      4'd5:    r = 3'd5;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd4;
      4'd8:    r = 3'd5;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd4;
      4'd11:   r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] face_of(input logic [3:0] k);
    logic [1:0] r;
    if (k < 4'd3) begin
      r = 2'd0;
    end else if (k < 4'd6) begin
      r = 2'd1;
    end else if (k < 4'd9) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  logic [3:0]       st_q, st_d;
  logic [2:0]       vidx_q, vidx_d;
  logic [2:0]       comp_q, comp_d;
  logic [1:0]       face_q, face_d;
  logic [3:0]       emit_q, emit_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q;

  logic signed [CW-1:0]    vp_q [6][3];
  logic signed [CW-1:0]    vt_q [6][2];
  logic signed [NRM_W-1:0] vn_q [6][3];
  logic signed [NRM_W-1:0] fn_q [4][3];
  logic signed [CW:0]      e1_q [3];
  logic signed [CW:0]      e2_q [3];
  logic signed [MW-1:0]    prod_q;
  logic signed [NORM_IN_W-1:0] x_q [3];

  logic                 ld, start;
  logic [2:0]           ma, mb;
  logic signed [CW-1:0] ld_p [3];
  logic signed [CW-1:0] ld_t [2];
  logic signed [CW:0]   sum;

  // midpoint operands / straight corner load
  always_comb begin
    ma = 3'd0;
    mb = 3'd1;
    case (vidx_q)
      3'd4:    begin ma = 3'd1; mb = 3'd2; end
      3'd5:    begin ma = 3'd0; mb = 3'd2; end
      default: begin ma = 3'd0; mb = 3'd1; end
    endcase
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      sum     = {vp_q[ma][c][CW-1], vp_q[ma][c]} + {vp_q[mb][c][CW-1], vp_q[mb][c]};
      ld_p[c] = sum[CW:1];
    end
    for (int c = 0; c < 2; c++) begin
      sum     = {vt_q[ma][c][CW-1], vt_q[ma][c]} + {vt_q[mb][c][CW-1], vt_q[mb][c]};
      ld_t[c] = sum[CW:1];
    end
    if (vidx_q < 3'd3) begin
      ld_p[0] = job_i.corner[vidx_q[1:0]].in_pos_x;
      ld_p[1] = job_i.corner[vidx_q[1:0]].in_pos_y;
      ld_p[2] = job_i.corner[vidx_q[1:0]].in_pos_z;
      ld_t[0] = job_i.corner[vidx_q[1:0]].in_tex_u;
      ld_t[1] = job_i.corner[vidx_q[1:0]].in_tex_v;
    end
  end

  always_comb begin
    norm_req_o.start = start;
    if (st_q == B_FSTART) begin
      norm_req_o.x = x_q[0];
      norm_req_o.y = x_q[1];
      norm_req_o.z = x_q[2];
    end else begin
      norm_req_o.x = NORM_IN_W'(ld_p[0]);
      norm_req_o.y = NORM_IN_W'(ld_p[1]);
      norm_req_o.z = NORM_IN_W'(ld_p[2]);
    end
  end

  // projection of one component: sign(n) * ((|n| * r + 8192) >> 14), saturated
  logic signed [NRM_W-1:0] pn;
  logic [NRM_W-1:0]        pn_mag;
  logic [PW-1:0]           pm;
  logic [PW:0]             pr;
  logic [QW-1:0]           pq;
  logic signed [CW-1:0]    proj_p;

  always_comb begin
    pn     = vn_q[vidx_q][comp_q[1:0]];
    pn_mag = pn[NRM_W-1] ? NRM_W'(-pn) : NRM_W'(pn);
    pm     = PW'(pn_mag[14:0]) * PW'(radius_i);
    pr     = (PW + 1)'(pm) + (PW + 1)'(8192);
    pq     = pr[PW:14];
    if (pn[NRM_W-1]) begin
      proj_p = (pq > QW'(CMAX + 1)) ? $signed({1'b1, {(CW - 1){1'b0}}}) : -$signed(CW'(pq));
    end else begin
      proj_p = (pq > QW'(CMAX)) ? $signed({1'b0, {(CW - 1){1'b1}}}) : $signed(CW'(pq));
    end
  end

  // cross product, one multiply per step
  logic [1:0]           oa, ob;
  logic signed [MW-1:0] mul;
  logic [3:0]           fk;

  always_comb begin
    oa = 2'd1;
    ob = 2'd2;
    case (comp_q)
      3'd0:    begin oa = 2'd1; ob = 2'd2; end
      3'd1:    begin oa = 2'd2; ob = 2'd1; end
      3'd2:    begin oa = 2'd2; ob = 2'd0; end
      3'd3:    begin oa = 2'd0; ob = 2'd2; end
      3'd4:    begin oa = 2'd0; ob = 2'd1; end
      3'd5:    begin oa = 2'd1; ob = 2'd0; end
      default: begin oa = 2'd1; ob = 2'd2; end
    endcase
    mul = MW'(e1_q[oa]) * MW'(e2_q[ob]);
  end

  assign fk = {1'b0, face_q, 1'b0} + {2'b00, face_q};

  logic [2:0] fa, fb, fc, esel;
  assign fa   = tri_vtx(fk);
  assign fb   = tri_vtx(fk + 4'd1);
  assign fc   = tri_vtx(fk + 4'd2);
  assign esel = tri_vtx(emit_q);

  always_comb begin
    st_d        = st_q;
    vidx_d      = vidx_q;
    comp_d      = comp_q;
    face_d      = face_q;
    emit_d      = emit_q;
    idx_d       = idx_q;
    job_pop_o   = 1'b0;
    start       = 1'b0;
    ld          = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          vidx_d = '0;
          st_d   = B_LOAD;
        end
      end
      B_LOAD: begin
        start = 1'b1;
        st_d  = B_NWAIT;
      end
      B_NWAIT: begin
        if (norm_rsp_i.done) begin
          comp_d = '0;
          st_d   = B_PROJ;
        end
      end
      B_PROJ: begin
        comp_d = comp_q + 3'd1;
        if (comp_q == 3'd2) begin
          if (vidx_q == 3'd5) begin
            if (face_mode_i) begin
              face_d = '0;
              st_d   = B_FDIFF;
            end else begin
              emit_d = '0;
              st_d   = B_EMIT;
            end
          end else begin
            vidx_d = vidx_q + 3'd1;
            st_d   = B_LOAD;
          end
        end
      end
      B_FDIFF: begin
        comp_d = '0;
        st_d   = B_FMUL;
      end
      B_FMUL: begin
        comp_d = comp_q + 3'd1;
        if (comp_q == 3'd5) begin
          st_d = B_FSTART;
        end
      end
      B_FSTART: begin
        start = 1'b1;
        st_d  = B_FWAIT;
      end
      B_FWAIT: begin
        if (norm_rsp_i.done) begin
          if (face_q == 2'd3) begin
            emit_d = '0;
            st_d   = B_EMIT;
          end else begin
            face_d = face_q + 2'd1;
            st_d   = B_FDIFF;
          end
        end
      end
      B_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          ld     = 1'b1;
          emit_d = emit_q + 4'd1;
          if (emit_q == LAST_VTX) begin
            idx_d     = idx_q + VTX_PER_TRI;
            job_pop_o = 1'b1;
            st_d      = B_IDLE;
          end
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  assign out_valid_d = ld || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      vidx_q      <= '0;
      comp_q      <= '0;
      face_q      <= '0;
      emit_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      vidx_q      <= vidx_d;
      comp_q      <= comp_d;
      face_q      <= face_d;
      emit_q      <= emit_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_LOAD) begin
      vt_q[vidx_q][0] <= ld_t[0];
      vt_q[vidx_q][1] <= ld_t[1];
    end
    if (st_q == B_NWAIT && norm_rsp_i.done) begin
      vn_q[vidx_q][0] <= norm_rsp_i.x;
      vn_q[vidx_q][1] <= norm_rsp_i.y;
      vn_q[vidx_q][2] <= norm_rsp_i.z;
    end
    if (st_q == B_PROJ) begin
      vp_q[vidx_q][comp_q[1:0]] <= proj_p;
    end
    if (st_q == B_FDIFF) begin
      for (int c = 0; c < 3; c++) begin
        e1_q[c] <= (CW + 1)'(vp_q[fb][c]) - (CW + 1)'(vp_q[fa][c]);
        e2_q[c] <= (CW + 1)'(vp_q[fc][c]) - (CW + 1)'(vp_q[fa][c]);
      end
    end
    if (st_q == B_FMUL) begin
      if (!comp_q[0]) begin
        prod_q <= mul;
      end else begin
        x_q[comp_q[2:1]] <= NORM_IN_W'(prod_q) - NORM_IN_W'(mul);
      end
    end
    if (st_q == B_FWAIT && norm_rsp_i.done) begin
      fn_q[face_q][0] <= norm_rsp_i.x;
      fn_q[face_q][1] <= norm_rsp_i.y;
      fn_q[face_q][2] <= norm_rsp_i.z;
    end
    if (ld) begin
      out_q.out_pos_x <= vp_q[esel][0];
      out_q.out_pos_y <= vp_q[esel][1];
      out_q.out_pos_z <= vp_q[esel][2];
      if (face_mode_i) begin
        out_q.out_norm_x <= fn_q[face_of(emit_q)][0];
        out_q.out_norm_y <= fn_q[face_of(emit_q)][1];
        out_q.out_norm_z <= fn_q[face_of(emit_q)][2];
      end else begin
        out_q.out_norm_x <= vn_q[esel][0];
        out_q.out_norm_y <= vn_q[esel][1];
        out_q.out_norm_z <= vn_q[esel][2];
      end
      out_q.out_tex_u        <= vt_q[esel][0];
      out_q.out_tex_v        <= vt_q[esel][1];
      out_q.out_vertex_index <= idx_q + IDX_W'(emit_q);
      out_q.out_last         <= (emit_q == LAST_VTX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign busy_o      = (st_q != B_IDLE);

endmodule

`default_nettype wire
